// File: rtl/pim_pkg.sv
// shared types, constants and helpers for the piece imbalance feature indexer
package pim_pkg;

  // clamp limit for a count difference and stride of the type code
  localparam int unsigned MAX_DIFF    = 8;
  localparam int unsigned TYPE_STRIDE = 8;

  localparam int unsigned NUM_TYPES = 5;
  localparam int unsigned NUM_PAIRS = 15;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned DIFF_W    = 5;
  localparam int unsigned TYPE_W    = 3;
  localparam int unsigned PAIR_W    = 4;
  localparam int unsigned INDEX_W   = 15;

  // largest offset pair value and largest untruncated index
  localparam int unsigned OFS_MAX   = 2 * MAX_DIFF;
  localparam int unsigned DPAIR_MAX = (2 * MAX_DIFF + 1) * OFS_MAX + OFS_MAX;
  localparam int unsigned DPAIR_W   = $clog2(DPAIR_MAX + 1);
  localparam int unsigned IDX_MAX   = TYPE_STRIDE * TYPE_STRIDE * DPAIR_MAX
                                      + TYPE_STRIDE * NUM_TYPES + NUM_TYPES;
  localparam int unsigned IDX_FULL_W = $clog2(IDX_MAX + 1);

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic [TYPE_W-1:0]        type_idx_t;

  localparam diff_t DIFF_LIMIT = diff_t'(MAX_DIFF);

  // type pair visiting order: first type is the outer loop, second the inner
  localparam type_idx_t PAIR_A [NUM_PAIRS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
    3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4
  };
  localparam type_idx_t PAIR_B [NUM_PAIRS] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd1, 3'd2, 3'd3,
    3'd4, 3'd2, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4
  };

  typedef struct packed {
    logic [CNT_W-1:0] white_pawns;
    logic [CNT_W-1:0] white_knights;
    logic [CNT_W-1:0] white_bishops;
    logic [CNT_W-1:0] white_rooks;
    logic [CNT_W-1:0] white_queens;
    logic [CNT_W-1:0] black_pawns;
    logic [CNT_W-1:0] black_knights;
    logic [CNT_W-1:0] black_bishops;
    logic [CNT_W-1:0] black_rooks;
    logic [CNT_W-1:0] black_queens;
    logic             view_side;
  } in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] feature_index;
    logic               last;
    logic               none_active;
  } out_t;

  // current pair handed from the item register to the result stage
  typedef struct packed {
    logic      valid;
    logic      none;
    logic      last;
    type_idx_t t0;
    type_idx_t t1;
    diff_t     d0;
    diff_t     d1;
  } pair_t;

  // own count minus opponent count, clamped to the allowed range
  function automatic diff_t clamp_diff(logic [CNT_W-1:0] own, logic [CNT_W-1:0] opp);
    diff_t d;
    d = $signed({1'b0, own}) - $signed({1'b0, opp});
    if (d > DIFF_LIMIT) begin
      d = DIFF_LIMIT;
    end else if (d < -DIFF_LIMIT) begin
      d = -DIFF_LIMIT;
    end
    return d;
  endfunction

endpackage

// File: rtl/pim_load.sv
// item register: clamped differences, active pair mask and pair selection
module pim_load (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pim_pkg::in_t  in_data_i,
  input  logic          take_i,
  output pim_pkg::pair_t cur_o
);

  logic                          slot_valid_q;
  pim_pkg::diff_t                diff_q [pim_pkg::NUM_TYPES];
  pim_pkg::diff_t                diff_d [pim_pkg::NUM_TYPES];
  logic [pim_pkg::NUM_PAIRS-1:0] mask_q;
  logic [pim_pkg::NUM_PAIRS-1:0] mask_d;
  logic [pim_pkg::NUM_PAIRS-1:0] low_bit;
  logic [pim_pkg::NUM_PAIRS-1:0] rest;
  logic [pim_pkg::NUM_TYPES-1:0] nz;
  logic [pim_pkg::CNT_W-1:0]     own_cnt [pim_pkg::NUM_TYPES];
  logic [pim_pkg::CNT_W-1:0]     opp_cnt [pim_pkg::NUM_TYPES];
  logic [pim_pkg::PAIR_W-1:0]    pos;
  logic                          in_accept;

  // viewing side's counts first
  always_comb begin
    if (in_data_i.view_side) begin
      own_cnt = '{in_data_i.black_pawns, in_data_i.black_knights, in_data_i.black_bishops,
                  in_data_i.black_rooks, in_data_i.black_queens};
      opp_cnt = '{in_data_i.white_pawns, in_data_i.white_knights, in_data_i.white_bishops,
                  in_data_i.white_rooks, in_data_i.white_queens};
    end else begin
      own_cnt = '{in_data_i.white_pawns, in_data_i.white_knights, in_data_i.white_bishops,
                  in_data_i.white_rooks, in_data_i.white_queens};
      opp_cnt = '{in_data_i.black_pawns, in_data_i.black_knights, in_data_i.black_bishops,
                  in_data_i.black_rooks, in_data_i.black_queens};
    end
  end

  // per-type differences and pairs with both differences nonzero
  always_comb begin
    for (int t = 0; t < pim_pkg::NUM_TYPES; t++) begin
      diff_d[t] = pim_pkg::clamp_diff(own_cnt[t], opp_cnt[t]);
      nz[t]     = (diff_d[t] != '0);
    end
    for (int p = 0; p < pim_pkg::NUM_PAIRS; p++) begin
      mask_d[p] = nz[pim_pkg::PAIR_A[p]] & nz[pim_pkg::PAIR_B[p]];
    end
  end

  // lowest pending pair goes next
  always_comb begin
    low_bit = mask_q & (~mask_q + 1'b1);
    rest    = mask_q & ~low_bit;
    pos     = '0;
    for (int p = 0; p < pim_pkg::NUM_PAIRS; p++) begin
      if (low_bit[p]) begin
        pos = pim_pkg::PAIR_W'(p);
      end
    end
  end

  always_comb begin
    cur_o.valid = slot_valid_q;
    cur_o.none  = (mask_q == '0);
    cur_o.last  = (rest == '0);
    cur_o.t0    = pim_pkg::PAIR_A[pos] + 1'b1;
    cur_o.t1    = pim_pkg::PAIR_B[pos] + 1'b1;
    cur_o.d0    = diff_q[pim_pkg::PAIR_A[pos]];
    cur_o.d1    = diff_q[pim_pkg::PAIR_B[pos]];
  end

  // a new item enters once the held one hands over its last result
  assign in_stall_o = slot_valid_q && !(take_i && cur_o.last);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else if (in_accept) begin
      slot_valid_q <= 1'b1;
    end else if (take_i && cur_o.last) begin
      slot_valid_q <= 1'b0;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      diff_q <= diff_d;
      mask_q <= mask_d;
    end else if (take_i) begin
      mask_q <= rest;
    end
  end

  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> slot_valid_q)
    else $error("pair taken with no item held");

  a_busy_accept_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && slot_valid_q) |-> (take_i && cur_o.last))
    else $error("item accepted over one still producing results");

  a_mask_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_i && !cur_o.last) |=>
      (slot_valid_q && ($countones(mask_q) == $countones($past(mask_q)) - 1)))
    else $error("pending pair mask did not lose exactly one pair");

endmodule

// File: rtl/pim_emit.sv
// result stage: feature index formation and output register
module pim_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pim_pkg::pair_t cur_i,
  output logic           take_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output pim_pkg::out_t  out_data_o
);

  logic [pim_pkg::DIFF_W-1:0]     ofs0;
  logic [pim_pkg::DIFF_W-1:0]     ofs1;
  logic [pim_pkg::DPAIR_W-1:0]    dpair;
  logic [pim_pkg::IDX_FULL_W-1:0] idx_full;
  logic                           out_valid_q;
  pim_pkg::out_t                  out_q;
  pim_pkg::out_t                  out_d;

  // offset differences, then the combined index
  always_comb begin
    ofs0  = $unsigned(cur_i.d0) + pim_pkg::DIFF_W'(pim_pkg::MAX_DIFF);
    ofs1  = $unsigned(cur_i.d1) + pim_pkg::DIFF_W'(pim_pkg::MAX_DIFF);
    dpair = pim_pkg::DPAIR_W'((2 * pim_pkg::MAX_DIFF + 1)) * pim_pkg::DPAIR_W'(ofs0)
            + pim_pkg::DPAIR_W'(ofs1);
    idx_full = pim_pkg::IDX_FULL_W'(pim_pkg::TYPE_STRIDE * pim_pkg::TYPE_STRIDE)
               * pim_pkg::IDX_FULL_W'(dpair)
               + pim_pkg::IDX_FULL_W'(pim_pkg::TYPE_STRIDE) * pim_pkg::IDX_FULL_W'(cur_i.t0)
               + pim_pkg::IDX_FULL_W'(cur_i.t1);
    if (cur_i.none) begin
      out_d.feature_index = '0;
      out_d.last          = 1'b1;
      out_d.none_active   = 1'b1;
    end else begin
      out_d.feature_index = idx_full[pim_pkg::INDEX_W-1:0];
      out_d.last          = cur_i.last;
      out_d.none_active   = 1'b0;
    end
  end

  // output register refills when empty or when its result transfers
  assign take_o = cur_i.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_none_is_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.none_active) |-> (out_q.last && (out_q.feature_index == '0)))
    else $error("empty-item result not marked last with a zero index");

  a_take_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> out_valid_q)
    else $error("output register empty after a pair was taken");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_i.valid && !cur_i.none) |-> (cur_i.t0 <= cur_i.t1))
    else $error("type pair out of order");

endmodule

// File: rtl/piece_imbalance_feature_indexer.sv
// top level of the piece imbalance feature indexer
//
// Each accepted position yields one result per type pair whose two clamped
// count differences are both nonzero (1 to 15 results, one per cycle while the
// output does not stall, in pair order), or a single result with none_active set
// when there is none; the final result of a position carries last. A position
// stays in the item register until its last result is taken, and the next
// position is accepted in the same cycle that its predecessor's last result moves
// into the output register, so the sustained rate is one result per cycle when
// the output does not stall. A result passes from the item register to the output
// register; a stall on the output holds both stages.
module piece_imbalance_feature_indexer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pim_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pim_pkg::out_t out_data_o
);

  pim_pkg::pair_t cur;
  logic           take;

  // item register and pair selection
  pim_load u_load (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .cur_o      (cur)
  );

  // index formation and output register
  pim_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cur_i       (cur),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the piece imbalance feature indexer
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_TICKS = 8;
  localparam int unsigned REPORT_MAX   = 10;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  pim_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  pim_pkg::out_t out_data_o;

  // expected feature results, oldest first
  pim_pkg::out_t feature_queue[$];

  int unsigned fail_count   = 0;
  int unsigned result_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_request = 0;
  int unsigned stall_left   = 0;
  bit          send_idles   = 1'b0;
  bit          recv_stalls  = 1'b0;

  piece_imbalance_feature_indexer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // idle length: mostly none, some short, a few long
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(40, 8);
  endfunction

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  // expected feature indices for one position, in pair order
  function automatic void predict_features(input pim_pkg::in_t pos);
    logic [pim_pkg::CNT_W-1:0] wc [pim_pkg::NUM_TYPES];
    logic [pim_pkg::CNT_W-1:0] bc [pim_pkg::NUM_TYPES];
    int   diff [pim_pkg::NUM_TYPES];
    int   lim;
    int   stride;
    int   idx;
    int   a;
    int   b;
    int   first;
    pim_pkg::out_t r;
    wc = '{pos.white_pawns, pos.white_knights, pos.white_bishops,
           pos.white_rooks, pos.white_queens};
    bc = '{pos.black_pawns, pos.black_knights, pos.black_bishops,
           pos.black_rooks, pos.black_queens};
    lim    = int'(pim_pkg::MAX_DIFF);
    stride = int'(pim_pkg::TYPE_STRIDE);
    first  = feature_queue.size();
    // clamped difference seen from the viewing side
    for (a = 0; a < pim_pkg::NUM_TYPES; a++) begin
      diff[a] = pos.view_side ? int'(bc[a]) - int'(wc[a]) : int'(wc[a]) - int'(bc[a]);
      if (diff[a] > lim) diff[a] = lim;
      if (diff[a] < -lim) diff[a] = -lim;
    end
    // one index per pair with both differences nonzero
    for (a = 0; a < pim_pkg::NUM_TYPES; a++) begin
      for (b = a; b < pim_pkg::NUM_TYPES; b++) begin
        if (diff[a] != 0 && diff[b] != 0) begin
          idx = ((2 * lim + 1) * (diff[a] + lim) + (diff[b] + lim)) * stride * stride
                + stride * (a + 1) + (b + 1);
          r.feature_index = idx[pim_pkg::INDEX_W-1:0];
          r.last          = 1'b0;
          r.none_active   = 1'b0;
          feature_queue   = {feature_queue, r};
        end
      end
    end
    if (feature_queue.size() == first) begin
      r.feature_index = '0;
      r.last          = 1'b1;
      r.none_active   = 1'b1;
      feature_queue   = {feature_queue, r};
    end else begin
      feature_queue[feature_queue.size() - 1].last = 1'b1;
    end
  endfunction

  // position with a mix of balanced, near and far counts per type
  function automatic pim_pkg::in_t random_position();
    logic [4*pim_pkg::NUM_TYPES-1:0] wv;
    logic [4*pim_pkg::NUM_TYPES-1:0] bv;
    logic [pim_pkg::CNT_W-1:0]       w;
    logic [pim_pkg::CNT_W-1:0]       k;
    int  t;
    int  a;
    bit  balanced;
    balanced = ($urandom_range(9) == 0);
    for (a = 0; a < pim_pkg::NUM_TYPES; a++) begin
      w = pim_pkg::CNT_W'($urandom_range(15));
      case ($urandom_range(9))
        0, 1, 2, 3: k = w;
        4, 5, 6: begin
          t = int'(w) + int'($urandom_range(6)) - 3;
          if (t < 0) t = 0;
          if (t > 15) t = 15;
          k = t[pim_pkg::CNT_W-1:0];
        end
        default: k = pim_pkg::CNT_W'($urandom_range(15));
      endcase
      if (balanced) k = w;
      wv = {wv[4*pim_pkg::NUM_TYPES-5:0], w};
      bv = {bv[4*pim_pkg::NUM_TYPES-5:0], k};
    end
    return pim_pkg::in_t'({wv, bv, 1'($urandom_range(1))});
  endfunction

  // offer one position and wait for its transfer
  task automatic send_position(input pim_pkg::in_t pos);
    int unsigned gap;
    gap = send_idles ? idle_length() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pos;
    do @(posedge clk_i); while (in_stall_o);
    predict_features(pos);
  endtask

  task automatic wait_for_drain();
    while (feature_queue.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls plus requested long hold-offs
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      stall_left   = hold_request;
      hold_request = 0;
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_left = recv_stalls ? idle_length() : 0;
      out_stall_i <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    pim_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_count++;
      if (feature_queue.size() == 0) begin
        note_failure($sformatf("result %0d with nothing expected: index %0d last %0b none %0b",
                               result_count, out_data_o.feature_index, out_data_o.last,
                               out_data_o.none_active));
      end else begin
        want = feature_queue.pop_front();
        if (out_data_o.feature_index !== want.feature_index ||
            out_data_o.last !== want.last || out_data_o.none_active !== want.none_active) begin
          note_failure($sformatf({"result %0d: expected index %0d last %0b none %0b, ",
                                  "got index %0d last %0b none %0b"},
                                 result_count, want.feature_index, want.last,
                                 want.none_active, out_data_o.feature_index,
                                 out_data_o.last, out_data_o.none_active));
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("piece_imbalance_feature_indexer regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // extremes, clamping, single types and no active pair
  task automatic test_directed();
    send_idles  = 1'b0;
    recv_stalls = 1'b0;
    // balanced boards give no active pair
    send_position(pim_pkg::in_t'({20'h00000, 20'h00000, 1'b0}));
    send_position(pim_pkg::in_t'({20'h37AF2, 20'h37AF2, 1'b1}));
    send_position(pim_pkg::in_t'({20'hFFFFF, 20'hFFFFF, 1'b0}));
    // every pair active at the clamp limits
    send_position(pim_pkg::in_t'({20'hFFFFF, 20'h00000, 1'b0}));
    send_position(pim_pkg::in_t'({20'hFFFFF, 20'h00000, 1'b1}));
    send_position(pim_pkg::in_t'({20'h00000, 20'hFFFFF, 1'b0}));
    send_position(pim_pkg::in_t'({20'h00000, 20'hFFFFF, 1'b1}));
    // one type out of balance yields one self pair
    send_position(pim_pkg::in_t'({20'h10000, 20'h00000, 1'b0}));
    send_position(pim_pkg::in_t'({20'h01000, 20'h00000, 1'b1}));
    send_position(pim_pkg::in_t'({20'h00100, 20'h00000, 1'b0}));
    send_position(pim_pkg::in_t'({20'h00010, 20'h00000, 1'b1}));
    send_position(pim_pkg::in_t'({20'h00001, 20'h00000, 1'b0}));
    // differences just inside and just beyond the limit
    send_position(pim_pkg::in_t'({20'h90000, 20'h10000, 1'b0}));
    send_position(pim_pkg::in_t'({20'h90000, 20'h00000, 1'b0}));
    send_position(pim_pkg::in_t'({20'h00008, 20'h00000, 1'b1}));
    send_position(pim_pkg::in_t'({20'h00000, 20'h00009, 1'b0}));
    send_position(pim_pkg::in_t'({20'h07000, 20'h00007, 1'b0}));
    // mixed signs and partial activity
    send_position(pim_pkg::in_t'({20'h83221, 20'h64211, 1'b0}));
    send_position(pim_pkg::in_t'({20'h83221, 20'h64211, 1'b1}));
    send_position(pim_pkg::in_t'({20'h1F0F1, 20'hF1F0F, 1'b0}));
    send_position(pim_pkg::in_t'({20'hE5A3C, 20'h2B4D6, 1'b1}));
    in_valid_i <= 1'b0;
    wait_for_drain();
  endtask

  // random positions with idles on both sides
  task automatic test_random_traffic(input int unsigned count);
    send_idles  = 1'b1;
    recv_stalls = 1'b1;
    repeat (count) send_position(random_position());
  endtask

  // back to back transfers with no idling at all
  task automatic test_full_rate(input int unsigned count);
    send_idles  = 1'b0;
    recv_stalls = 1'b0;
    repeat (count) send_position(random_position());
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_output_hold(input int unsigned count);
    send_idles   = 1'b0;
    recv_stalls  = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (count) send_position(random_position());
  endtask

  // sender pauses until every result is out, between bursts
  task automatic test_drain_pauses(input int unsigned bursts);
    send_idles  = 1'b1;
    recv_stalls = 1'b1;
    repeat (bursts) begin
      repeat ($urandom_range(12, 1)) send_position(random_position());
      in_valid_i <= 1'b0;
      wait_for_drain();
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_traffic(140);
    test_full_rate(50);
    test_output_hold(20);
    test_drain_pauses(6);
    test_random_traffic(40);
    // let the last results come out, then settle
    in_valid_i <= 1'b0;
    wait_for_drain();
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (feature_queue.size() != 0) begin
      note_failure($sformatf("%0d expected results never came", feature_queue.size()));
    end
    if (fail_count == 0) begin
      $display("piece_imbalance_feature_indexer regression: pass");
    end else begin
      $display("piece_imbalance_feature_indexer regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pim_pkg.sv
rtl/pim_load.sv
rtl/pim_emit.sv
rtl/piece_imbalance_feature_indexer.sv
tb/sv/testbench.sv
